// ----- rtl/core/cfa_pkg.sv -----
// Shared types and constants of the contiguous fit allocator.
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

  localparam int UNITS  = 256;
  localparam int ADDR_W = $clog2(UNITS);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int PC_W   = 4;

  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_FREE    = 1'b1;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_WORST = 2'd1;
  localparam logic [1:0] MODE_BEST  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    logic              operation;
    logic [CNT_W-1:0]  length;
    logic [ADDR_W-1:0] start_unit;
  } cfa_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] placed_start;
    logic [CNT_W-1:0]  used_units;
  } cfa_out_t;

  // Jump conditions of the microprogram.
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_REQ,
    C_IS_ALLOC,
    C_FREE_BAD,
    C_LEN_ZERO,
    C_IDX_NOT_LAST,
    C_IDX_NOT_END,
    C_CNT_NOT_LAST,
    C_NO_PICK,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            accept;
    logic            clr_wr;
    logic            idx_inc;
    logic            eval;
    logic            eval_end;
    logic            rd_free;
    logic            mark;
    logic            cnt_inc;
    logic            set_st;
    status_t         st;
    logic            set_placed;
    logic            load_out;
  } cfa_ctrl_t;

  typedef struct packed {
    logic no_req;
    logic is_alloc;
    logic free_bad;
    logic len_zero;
    logic idx_not_last;
    logic idx_not_end;
    logic cnt_not_last;
    logic no_pick;
    logic out_busy;
  } cfa_flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/cfa_seq.sv -----
// Microprogram sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps
`default_nettype none

module cfa_seq (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire cfa_pkg::cfa_flags_t flags,
  output cfa_pkg::cfa_ctrl_t       ctrl
);
  import cfa_pkg::*;

  localparam logic [PC_W-1:0] S_CLEAR    = 4'd0;
  localparam logic [PC_W-1:0] S_IDLE     = 4'd1;
  localparam logic [PC_W-1:0] S_DISP     = 4'd2;
  localparam logic [PC_W-1:0] S_F_CHK    = 4'd3;
  localparam logic [PC_W-1:0] S_F_LOOP   = 4'd4;
  localparam logic [PC_W-1:0] S_F_DRAIN  = 4'd5;
  localparam logic [PC_W-1:0] S_A_CHK    = 4'd6;
  localparam logic [PC_W-1:0] S_PRIME    = 4'd7;
  localparam logic [PC_W-1:0] S_SCAN     = 4'd8;
  localparam logic [PC_W-1:0] S_SCAN_END = 4'd9;
  localparam logic [PC_W-1:0] S_MARK     = 4'd10;
  localparam logic [PC_W-1:0] S_RESULT   = 4'd11;
  localparam logic [PC_W-1:0] S_RETURN   = 4'd12;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  function automatic cfa_ctrl_t rom(input logic [PC_W-1:0] a);
    cfa_ctrl_t w;
    w        = '0;
    w.cond   = C_NEXT;
    w.st     = ST_OK;
    w.target = S_IDLE;
    unique case (a)
      S_CLEAR: begin
        w.clr_wr = 1'b1; w.idx_inc = 1'b1;
        w.cond = C_IDX_NOT_LAST; w.target = S_CLEAR;
      end
      S_IDLE: begin
        w.accept = 1'b1; w.cond = C_NO_REQ; w.target = S_IDLE;
      end
      S_DISP: begin
        w.cond = C_IS_ALLOC; w.target = S_A_CHK;
      end
      S_F_CHK: begin
        w.set_st = 1'b1; w.st = ST_RANGE;
        w.cond = C_FREE_BAD; w.target = S_RESULT;
      end
      S_F_LOOP: begin
        w.rd_free = 1'b1; w.cnt_inc = 1'b1; w.set_st = 1'b1; w.st = ST_OK;
        w.cond = C_CNT_NOT_LAST; w.target = S_F_LOOP;
      end
      S_F_DRAIN: begin
        w.cond = C_ALWAYS; w.target = S_RESULT;
      end
      S_A_CHK: begin
        w.set_st = 1'b1; w.st = ST_RANGE;
        w.cond = C_LEN_ZERO; w.target = S_RESULT;
      end
      S_PRIME: begin
        w.idx_inc = 1'b1;
      end
      S_SCAN: begin
        w.eval = 1'b1; w.idx_inc = 1'b1;
        w.cond = C_IDX_NOT_END; w.target = S_SCAN;
      end
      S_SCAN_END: begin
        w.eval_end = 1'b1; w.set_st = 1'b1; w.st = ST_NOSPACE;
        w.cond = C_NO_PICK; w.target = S_RESULT;
      end
      S_MARK: begin
        w.mark = 1'b1; w.cnt_inc = 1'b1; w.set_st = 1'b1; w.st = ST_OK;
        w.set_placed = 1'b1;
        w.cond = C_CNT_NOT_LAST; w.target = S_MARK;
      end
      S_RESULT: begin
        w.load_out = 1'b1; w.cond = C_OUT_BUSY; w.target = S_RESULT;
      end
      S_RETURN: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  assign ctrl = rom(pc_r);

  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:         take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NO_REQ:       take = flags.no_req;
      C_IS_ALLOC:     take = flags.is_alloc;
      C_FREE_BAD:     take = flags.free_bad;
      C_LEN_ZERO:     take = flags.len_zero;
      C_IDX_NOT_LAST: take = flags.idx_not_last;
      C_IDX_NOT_END:  take = flags.idx_not_end;
      C_CNT_NOT_LAST: take = flags.cnt_not_last;
      C_NO_PICK:      take = flags.no_pick;
      C_OUT_BUSY:     take = flags.out_busy;
      default:        take = 1'b0;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_CLEAR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/contiguous_fit_allocator.sv -----
// Top level of the contiguous fit allocator: occupancy map and datapath.
//
// A request on the in_ channel either allocates a contiguous run of units
// (first, worst or best fit, as cfg_wdata last set the mode) or frees a
// range. Each request gives exactly one result on the out_ channel with
// its status, the start of the placed run and the count of used units.
// Requests are handled one at a time by a microprogram over a 256 x 1
// occupancy memory with one read and one write port.
// An allocation makes one full scan of the map at one unit a cycle, then
// marks the chosen run at one unit a cycle. A free works at one unit a
// cycle with the read and clear overlapped. Failed checks go straight to
// the result. In each case the result appears before the next request
// can be taken.
// After reset a clearing pass over all 256 units empties the map;
// in_stall is high meanwhile, while mode writes are taken at any time.
// The result waits in an output register; when out_stall holds it there,
// the next request is still taken and worked on, and its result waits
// until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_fit_allocator (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire cfa_pkg::cfa_in_t  in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output cfa_pkg::cfa_out_t      out_data,
  input  wire                    cfg_we,
  input  wire [1:0]              cfg_wdata
);
  import cfa_pkg::*;

  cfa_ctrl_t  ctrl;
  cfa_flags_t flags;

  logic              map_mem [UNITS];
  logic              rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_data;

  logic [1:0]        fit_mode_r;
  cfa_in_t           req_r;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] run_start_r;
  logic [CNT_W-1:0]  run_len_r;
  logic [ADDR_W-1:0] pick_start_r;
  logic [CNT_W-1:0]  pick_len_r;
  logic              have_r;
  logic [CNT_W-1:0]  used_r;
  status_t           status_r;
  logic [ADDR_W-1:0] placed_r;
  logic              pend_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic              out_valid_r;
  cfa_out_t          out_r;

  logic              accept;
  logic              busy;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] free_addr;
  logic [ADDR_W-1:0] mark_addr;
  logic              better;
  logic [CNT_W:0]    free_end;

  cfa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign accept    = ctrl.accept & in_valid;
  assign in_stall  = ~ctrl.accept;
  assign busy      = ctrl.eval_end | rd_data_r;
  assign pos       = ADDR_W'(idx_r - CNT_W'(1));
  assign free_addr = ADDR_W'(CNT_W'(req_r.start_unit) + cnt_r);
  assign mark_addr = ADDR_W'(CNT_W'(pick_start_r) + cnt_r);
  assign free_end  = (CNT_W + 1)'(req_r.start_unit) + (CNT_W + 1)'(req_r.length);

  always_comb begin
    case (fit_mode_r)
      MODE_WORST: better = ~have_r | (run_len_r > pick_len_r);
      MODE_BEST:  better = ~have_r | (run_len_r < pick_len_r);
      default:    better = ~have_r;
    endcase
  end

  always_comb begin
    flags.no_req       = ~in_valid;
    flags.is_alloc     = (req_r.operation == OP_ALLOC);
    flags.free_bad     = (req_r.length == '0) || (free_end > (CNT_W + 1)'(UNITS));
    flags.len_zero     = (req_r.length == '0);
    flags.idx_not_last = (idx_r != CNT_W'(UNITS - 1));
    flags.idx_not_end  = (idx_r != CNT_W'(UNITS));
    flags.cnt_not_last = (cnt_r != req_r.length - CNT_W'(1));
    // The run that ends at the last unit is closed in the same step, so it counts too.
    flags.no_pick      = ~have_r & (run_len_r < req_r.length);
    flags.out_busy     = out_valid_r & out_stall;
  end

  // One write port: clearing pass, marking, or the delayed clear of a free.
  always_comb begin
    rd_addr = ctrl.rd_free ? free_addr : idx_r[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_r[ADDR_W-1:0];
    wr_data = 1'b0;
    if (ctrl.clr_wr) begin
      wr_en = 1'b1;
    end else if (ctrl.mark) begin
      wr_en   = 1'b1;
      wr_addr = mark_addr;
      wr_data = 1'b1;
    end else if (pend_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r  <= MODE_FIRST;
      idx_r       <= '0;
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fit_mode_r <= cfg_wdata;
      end

      if (accept) begin
        req_r     <= in_data;
        idx_r     <= '0;
        cnt_r     <= '0;
        run_len_r <= '0;
        have_r    <= 1'b0;
        placed_r  <= '0;
      end else begin
        if (ctrl.idx_inc) begin
          idx_r <= idx_r + CNT_W'(1);
        end
        if (ctrl.cnt_inc) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        // Run tracking: the read data belongs to the unit one behind idx_r.
        if (ctrl.eval || ctrl.eval_end) begin
          if (!busy) begin
            if (run_len_r == '0) begin
              run_start_r <= pos;
            end
            run_len_r <= run_len_r + CNT_W'(1);
          end else begin
            if ((run_len_r >= req_r.length) && better) begin
              pick_start_r <= run_start_r;
              pick_len_r   <= run_len_r;
              have_r       <= 1'b1;
            end
            run_len_r <= '0;
          end
        end
        if (ctrl.set_st) begin
          status_r <= ctrl.st;
        end
        if (ctrl.set_placed) begin
          placed_r <= pick_start_r;
        end
      end

      // The chosen run is wholly free, so every marked unit adds one.
      if (ctrl.mark) begin
        used_r <= used_r + CNT_W'(1);
      end else if (pend_r && rd_data_r) begin
        used_r <= used_r - CNT_W'(1);
      end

      pend_r      <= ctrl.rd_free;
      pend_addr_r <= free_addr;

      if (ctrl.load_out && !flags.out_busy) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out && !flags.out_busy) begin
      out_r.status       <= status_r;
      out_r.placed_start <= placed_r;
      out_r.used_units   <= used_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/core/cfa_checker.sv -----
// Port-level checker for the contiguous fit allocator, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module cfa_port_props (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_valid,
  input wire                    in_stall,
  input wire cfa_pkg::cfa_in_t  in_data,
  input wire                    out_valid,
  input wire                    out_stall,
  input wire cfa_pkg::cfa_out_t out_data
);
  import cfa_pkg::*;

  // A stalled request holds.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A failed request never reports a placement.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.placed_start == '0)
    else $error("placement reported on failed request");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.used_units <= CNT_W'(UNITS))
    else $error("used count beyond map size");

  // Reset drops any result and starts the clearing pass with requests held off.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("block not quiet after reset");

endmodule

bind contiguous_fit_allocator cfa_port_props u_cfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- test/cfa_checker.sv -----
// Checker for the contiguous fit allocator: predicts each request's result and compares.
`timescale 1ns / 1ps

module cfa_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_stall,
  input  cfa_pkg::cfa_in_t   in_data,
  input  wire                out_valid,
  input  wire                out_stall,
  input  cfa_pkg::cfa_out_t  out_data,
  input  wire                cfg_we,
  input  wire [1:0]          cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  import cfa_pkg::*;

  bit [UNITS-1:0] unit_busy;
  int             used_total;
  logic [1:0]     fit_mode;
  cfa_out_t       results_due[$];
  int             fails;

  initial begin
    fail_count = 0;
    pending    = 0;
    fails      = 0;
  end

  // Applies one request to the shadow map and returns the result it should give.
  function automatic cfa_out_t apply_request(cfa_in_t req);
    cfa_out_t res;
    int       run_at;
    int       run_len;
    int       pick_at;
    int       pick_len;
    int       first;
    int       span;
    bit       have;
    bit       blocked;
    res        = '0;
    res.status = ST_OK;
    span       = int'(req.length);
    first      = int'(req.start_unit);
    if (req.operation == OP_ALLOC) begin
      if (span == 0) begin
        res.status = ST_RANGE;
      end else begin
        run_at   = 0;
        run_len  = 0;
        pick_at  = 0;
        pick_len = 0;
        have     = 1'b0;
        // The position one past the last unit closes the final run.
        for (int u = 0; u <= UNITS; u++) begin
          blocked = (u == UNITS) ? 1'b1 : unit_busy[u];
          if (!blocked) begin
            if (run_len == 0) run_at = u;
            run_len++;
          end else begin
            if (run_len >= span) begin
              if (!have || (fit_mode == MODE_WORST && run_len > pick_len) ||
                  (fit_mode == MODE_BEST && run_len < pick_len)) begin
                pick_at  = run_at;
                pick_len = run_len;
                have     = 1'b1;
              end
            end
            run_len = 0;
          end
        end
        if (!have) begin
          res.status = ST_NOSPACE;
        end else begin
          for (int u = pick_at; u < pick_at + span && u < UNITS; u++) begin
            if (!unit_busy[u]) begin
              unit_busy[u] = 1'b1;
              used_total++;
            end
          end
          res.placed_start = ADDR_W'(pick_at);
        end
      end
    end else begin
      if (span == 0 || first + span > UNITS) begin
        res.status = ST_RANGE;
      end else begin
        for (int u = first; u < first + span; u++) begin
          if (unit_busy[u]) begin
            unit_busy[u] = 1'b0;
            used_total--;
          end
        end
      end
    end
    res.used_units = CNT_W'(used_total);
    return res;
  endfunction

  always @(posedge clk) begin
    cfa_out_t want;
    if (!rst_n) begin
      unit_busy  = '0;
      used_total = 0;
      fit_mode   = MODE_FIRST;
      results_due.delete();
    end else begin
      if (cfg_we) fit_mode = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          fails++;
          $display("%0t: result with no request pending: status %0d start %0d used %0d",
                   $time, out_data.status, out_data.placed_start, out_data.used_units);
        end else begin
          want = results_due.pop_front();
          if (out_data.status !== want.status) begin
            fails++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_data.status);
          end
          if (out_data.placed_start !== want.placed_start) begin
            fails++;
            $display("%0t: placed_start expected %0d actual %0d",
                     $time, want.placed_start, out_data.placed_start);
          end
          if (out_data.used_units !== want.used_units) begin
            fails++;
            $display("%0t: used_units expected %0d actual %0d",
                     $time, want.used_units, out_data.used_units);
          end
        end
      end
      if (in_valid && !in_stall) results_due.push_back(apply_request(in_data));
    end
    fail_count <= fails;
    pending    <= results_due.size();
  end

endmodule

// ----- test/contiguous_fit_allocator_tb.sv -----
// Testbench top for the contiguous fit allocator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module contiguous_fit_allocator_tb;
  import cfa_pkg::*;

  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         CYCLE_LIMIT = 3000000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  cfa_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  cfa_out_t          out_data;
  logic              cfg_we    = 1'b0;
  logic [1:0]        cfg_wdata = MODE_FIRST;
  int                fail_count;
  int                pending;
  int                cycle_count = 0;
  int                hold_off    = 0;
  bit                no_idle     = 1'b0;
  logic [1:0]        phase_modes [7] = '{MODE_FIRST, MODE_BEST, MODE_WORST, MODE_SPARE,
                                         MODE_BEST, MODE_FIRST, MODE_WORST};

  always #10 clk = ~clk;

  contiguous_fit_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cfa_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL contiguous_fit_allocator");
      $finish;
    end
  end

  // Result side: random stalls before results unless no_idle; a long hold-off when asked for.
  initial begin
    int n;
    forever begin
      if (hold_off != 0) begin
        n        = hold_off;
        hold_off = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  task automatic issue_request(input logic op, input logic [CNT_W-1:0] len,
                               input logic [ADDR_W-1:0] first);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data.operation  <= op;
    in_data.length     <= len;
    in_data.start_unit <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering requests and waits until every result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly short allocations and frees so that the map fragments; a few long or malformed ones.
  task automatic issue_random();
    int               pick;
    logic [CNT_W-1:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 52)      len = CNT_W'($urandom_range(1, 24));
    else if (pick < 58) len = CNT_W'($urandom_range(25, 511));
    else if (pick < 95) len = CNT_W'($urandom_range(1, 32));
    else if (pick < 98) len = CNT_W'($urandom_range(0, 511));
    else                len = '0;
    issue_request((pick < 58 || pick == 99) ? OP_ALLOC : OP_FREE, len,
                  ADDR_W'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_mode(MODE_FIRST);

    issue_request(OP_ALLOC, 9'd0, 8'hff);
    issue_request(OP_FREE, 9'd0, 8'd0);
    issue_request(OP_ALLOC, 9'd256, 8'h5a);
    issue_request(OP_ALLOC, 9'd1, 8'd0);
    issue_request(OP_FREE, 9'd2, 8'd255);
    issue_request(OP_FREE, 9'd256, 8'd0);
    issue_request(OP_ALLOC, 9'd511, 8'd0);
    issue_request(OP_FREE, 9'd1, 8'd255);
    issue_request(OP_ALLOC, 9'd10, 8'd0);
    issue_request(OP_ALLOC, 9'd20, 8'd0);
    issue_request(OP_ALLOC, 9'd5, 8'd0);
    issue_request(OP_ALLOC, 9'd30, 8'd0);
    issue_request(OP_FREE, 9'd10, 8'd0);
    issue_request(OP_FREE, 9'd5, 8'd30);
    // This free straddles used and already free units.
    issue_request(OP_FREE, 9'd12, 8'd28);
    drain();
    set_mode(MODE_BEST);
    issue_request(OP_ALLOC, 9'd10, 8'd0);
    issue_request(OP_ALLOC, 9'd11, 8'd0);
    drain();
    set_mode(MODE_WORST);
    issue_request(OP_ALLOC, 9'd4, 8'd0);
    drain();
    set_mode(MODE_SPARE);
    issue_request(OP_ALLOC, 9'd1, 8'd0);
    issue_request(OP_FREE, 9'd255, 8'd1);
    issue_request(OP_FREE, 9'd511, 8'd0);
    issue_request(OP_ALLOC, 9'd256, 8'd0);

    for (int p = 0; p < 7; p++) begin
      drain();
      set_mode(phase_modes[p]);
      no_idle = (p == 2);
      for (int k = 0; k < 200; k++) begin
        // Hold the result side long enough for the block to back up its request side.
        if (p == 1 && k == 40) hold_off = 3000;
        if (p == 4 && k == 100) drain();
        issue_random();
      end
    end

    drain();
    repeat (800) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS contiguous_fit_allocator");
    end else begin
      $display("FAIL contiguous_fit_allocator");
    end
    $finish;
  end

endmodule
